/* rtl/chs_pkg.sv */
// Shared types and constants for the compass heading and sector pipeline.
`default_nettype none

package chs_pkg;

  // Datapath widths: 16-bit reading, 8 guard bits, CORDIC gain and sign headroom.
  localparam int unsigned GUARD_BITS  = 8;
  localparam int unsigned XY_WIDTH    = 28;
  localparam int unsigned Z_WIDTH     = 26;
  localparam int unsigned T_WIDTH     = 25;
  localparam int unsigned ATAN_WIDTH  = 22;
  localparam int unsigned ATAN_LEN    = 24;
  localparam int unsigned HEAD_WIDTH  = 15;
  localparam int unsigned SECTORS     = 8;

  // Angle in 1/65536 degree.
  localparam logic signed [Z_WIDTH-1:0] HALF_CIRCLE_Z = 26'sd11796480;
  localparam logic signed [Z_WIDTH-1:0] FULL_CIRCLE_Z = 26'sd23592960;

  // Heading in 1/64 degree.
  localparam logic [HEAD_WIDTH-1:0] HEAD_NORTH = 15'd0;
  localparam logic [HEAD_WIDTH-1:0] HEAD_EAST  = 15'd5760;
  localparam logic [HEAD_WIDTH-1:0] HEAD_SOUTH = 15'd11520;
  localparam logic [HEAD_WIDTH-1:0] HEAD_WEST  = 15'd17280;
  localparam logic [HEAD_WIDTH-1:0] HEAD_FULL  = 15'd23040;
  localparam logic [HEAD_WIDTH-1:0] SECTOR_HALF  = 15'd1440;
  localparam logic [HEAD_WIDTH-1:0] SECTOR_WIDTH = 15'd2880;

  // atan(2^-i) in degrees, scaled by 65536 and rounded.
  localparam logic [ATAN_WIDTH-1:0] ATAN_Q16 [ATAN_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  typedef struct packed {
    logic signed [15:0] field_x;
    logic signed [15:0] field_y;
  } sample_t;

  typedef struct packed {
    logic [HEAD_WIDTH-1:0] heading;
    logic [2:0]            sector;
  } result_t;

  // Rotation state carried down the CORDIC stages.
  typedef struct packed {
    logic signed [XY_WIDTH-1:0] x;
    logic signed [XY_WIDTH-1:0] y;
    logic signed [Z_WIDTH-1:0]  z;
    logic                       special;
    logic [HEAD_WIDTH-1:0]      special_heading;
  } rot_t;

  // Wrapped angle and axis override after the CORDIC.
  typedef struct packed {
    logic [T_WIDTH-1:0]    t;
    logic                  special;
    logic [HEAD_WIDTH-1:0] special_heading;
  } angle_t;

endpackage

`default_nettype wire

/* rtl/chs_prep.sv */
// Input stage: scale, fold the left half-plane, flag readings on an axis.
`default_nettype none

module chs_prep (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_stall,
  input  chs_pkg::sample_t up_data,
  output logic             down_valid,
  input  logic             down_stall,
  output chs_pkg::rot_t    down_data
);

  logic                                 valid;
  chs_pkg::rot_t                        data;
  chs_pkg::rot_t                        data_next;
  logic signed [chs_pkg::XY_WIDTH-1:0]  xs;
  logic signed [chs_pkg::XY_WIDTH-1:0]  ys;
  logic                                 neg;

  assign up_stall = valid && down_stall;

  always_comb begin
    xs  = {{(chs_pkg::XY_WIDTH - 16 - chs_pkg::GUARD_BITS){up_data.field_x[15]}},
           up_data.field_x, {chs_pkg::GUARD_BITS{1'b0}}};
    ys  = {{(chs_pkg::XY_WIDTH - 16 - chs_pkg::GUARD_BITS){up_data.field_y[15]}},
           up_data.field_y, {chs_pkg::GUARD_BITS{1'b0}}};
    neg = up_data.field_x[15];
    data_next.x = neg ? -xs : xs;
    data_next.y = neg ? -ys : ys;
    data_next.z = neg ? chs_pkg::HALF_CIRCLE_Z : '0;
    data_next.special = (up_data.field_x == 16'sd0) || (up_data.field_y == 16'sd0);
    // Y on zero covers the origin too, so test it first.
    if (up_data.field_y == 16'sd0) begin
      data_next.special_heading = neg ? chs_pkg::HEAD_SOUTH : chs_pkg::HEAD_NORTH;
    end else begin
      data_next.special_heading = up_data.field_y[15] ? chs_pkg::HEAD_WEST
                                                      : chs_pkg::HEAD_EAST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      data <= data_next;
    end
  end

  assign down_valid = valid;
  assign down_data  = data;

endmodule

`default_nettype wire

/* rtl/chs_cordic_stage.sv */
// One vectoring CORDIC micro-rotation with its pipeline register.
`default_nettype none

module chs_cordic_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_stall,
  input  chs_pkg::rot_t up_data,
  output logic          down_valid,
  input  logic          down_stall,
  output chs_pkg::rot_t down_data
);

  localparam logic [4:0] IDX = 5'(SHIFT);

  logic                                valid;
  chs_pkg::rot_t                       data;
  chs_pkg::rot_t                       data_next;
  logic signed [chs_pkg::XY_WIDTH-1:0] dx;
  logic signed [chs_pkg::XY_WIDTH-1:0] dy;
  logic signed [chs_pkg::Z_WIDTH-1:0]  ang;
  logic                                y_pos;

  assign up_stall = valid && down_stall;

  always_comb begin
    dx    = up_data.y >>> SHIFT;
    dy    = up_data.x >>> SHIFT;
    ang   = {{(chs_pkg::Z_WIDTH - chs_pkg::ATAN_WIDTH){1'b0}}, chs_pkg::ATAN_Q16[IDX]};
    y_pos = !up_data.y[chs_pkg::XY_WIDTH-1] && (up_data.y != '0);
    data_next = up_data;
    // Rotate toward the X axis.
    if (y_pos) begin
      data_next.x = up_data.x + dx;
      data_next.y = up_data.y - dy;
      data_next.z = up_data.z + ang;
    end else begin
      data_next.x = up_data.x - dx;
      data_next.y = up_data.y + dy;
      data_next.z = up_data.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      data <= data_next;
    end
  end

  assign down_valid = valid;
  assign down_data  = data;

endmodule

`default_nettype wire

/* rtl/chs_wrap.sv */
// Post-CORDIC stage: wrap a negative angle into the full circle.
`default_nettype none

module chs_wrap (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_stall,
  input  chs_pkg::rot_t   up_data,
  output logic            down_valid,
  input  logic            down_stall,
  output chs_pkg::angle_t down_data
);

  logic                               valid;
  chs_pkg::angle_t                    data;
  chs_pkg::angle_t                    data_next;
  logic signed [chs_pkg::Z_WIDTH-1:0] t_full;

  assign up_stall = valid && down_stall;

  always_comb begin
    t_full = up_data.z[chs_pkg::Z_WIDTH-1] ? up_data.z + chs_pkg::FULL_CIRCLE_Z : up_data.z;
    data_next.t               = t_full[chs_pkg::T_WIDTH-1:0];
    data_next.special         = up_data.special;
    data_next.special_heading = up_data.special_heading;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      data <= data_next;
    end
  end

  assign down_valid = valid;
  assign down_data  = data;

endmodule

`default_nettype wire

/* rtl/chs_round.sv */
// Round the angle to 1/64 degree, wrap 360 to 0, apply the axis override.
`default_nettype none

module chs_round (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               up_valid,
  output logic                               up_stall,
  input  chs_pkg::angle_t                    up_data,
  output logic                               down_valid,
  input  logic                               down_stall,
  output logic [chs_pkg::HEAD_WIDTH-1:0]     down_data
);

  logic                            valid;
  logic [chs_pkg::HEAD_WIDTH-1:0]  data;
  logic [chs_pkg::HEAD_WIDTH-1:0]  data_next;
  logic [chs_pkg::T_WIDTH:0]       t_round;
  logic [chs_pkg::HEAD_WIDTH-1:0]  h;

  assign up_stall = valid && down_stall;

  always_comb begin
    t_round = {1'b0, up_data.t} + (chs_pkg::T_WIDTH + 1)'(512);
    h       = t_round[10 +: chs_pkg::HEAD_WIDTH];
    if (h >= chs_pkg::HEAD_FULL) begin
      h = h - chs_pkg::HEAD_FULL;
    end
    data_next = up_data.special ? up_data.special_heading : h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      data <= data_next;
    end
  end

  assign down_valid = valid;
  assign down_data  = data;

endmodule

`default_nettype wire

/* rtl/chs_sector.sv */
// Output stage: classify the heading into one of eight compass sectors.
`default_nettype none

module chs_sector (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           up_valid,
  output logic                           up_stall,
  input  logic [chs_pkg::HEAD_WIDTH-1:0] up_data,
  output logic                           down_valid,
  input  logic                           down_stall,
  output chs_pkg::result_t               down_data
);

  logic                         valid;
  chs_pkg::result_t             data;
  chs_pkg::result_t             data_next;
  logic [chs_pkg::SECTORS-1:0]  past;

  assign up_stall = valid && down_stall;

  // Count the boundaries at 22.5 + 45k degrees that lie at or below the heading;
  // passing all eight wraps back to North.
  always_comb begin
    for (int k = 0; k < chs_pkg::SECTORS; k++) begin
      past[k] = up_data >= chs_pkg::SECTOR_HALF
                + chs_pkg::HEAD_WIDTH'(k) * chs_pkg::SECTOR_WIDTH;
    end
    data_next.heading = up_data;
    data_next.sector  = 3'($countones(past));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!up_stall) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      data <= data_next;
    end
  end

  assign down_valid = valid;
  assign down_data  = data;

endmodule

`default_nettype wire

/* rtl/compass_heading_sector_core.sv */
// Compass heading and eight-way sector from a magnetometer X/Y pair.
// Accepts one signed 16-bit (field_x, field_y) request per unstalled cycle and
// returns the heading atan2(field_y, field_x) in 1/64 degree, wrapped into
// [0, 360), together with the compass sector (0 N, 1 NE, ... 7 NW, each 45
// degrees wide with North centred on 0). The heading comes from a vectoring
// CORDIC with one register stage per micro-rotation: the readings are scaled
// by 2^8, vectors in the left half-plane are turned by 180 degrees, and
// CORDIC_STAGES (at most 24) rotations drive Y to zero while the angle
// accumulates. Readings on an axis bypass the rotation and give exactly 0, 90,
// 180 or 270 degrees (the origin reads as North). Throughput is one request
// every unstalled clock. The stages are one input stage, one stage per rotation,
// one wrap stage, one rounding stage and the sector output register. Every stage
// holds its own valid bit, so bubbles close up under result_stall and a new
// request is taken whenever the first stage is empty or moving; sample_stall
// follows result_stall back through the stage chain in the same cycle.
`default_nettype none

module compass_heading_sector_core #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  chs_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output chs_pkg::result_t result
);

  // The arctangent table ends at 2^-23; stages beyond it add nothing.
  localparam int unsigned NUM_STAGES =
    (CORDIC_STAGES > chs_pkg::ATAN_LEN) ? chs_pkg::ATAN_LEN : CORDIC_STAGES;

  // Rotation pipeline: index 0 is the input stage, index i+1 follows rotation i.
  logic          rot_valid [NUM_STAGES+1];
  logic          rot_stall [NUM_STAGES+1];
  chs_pkg::rot_t rot_data  [NUM_STAGES+1];

  logic                           ang_valid;
  logic                           ang_stall;
  chs_pkg::angle_t                ang_data;
  logic                           head_valid;
  logic                           head_stall;
  logic [chs_pkg::HEAD_WIDTH-1:0] head_data;

  // Scale, fold and flag axis readings.
  chs_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (sample_valid),
    .up_stall   (sample_stall),
    .up_data    (sample),
    .down_valid (rot_valid[0]),
    .down_stall (rot_stall[0]),
    .down_data  (rot_data[0])
  );

  // One micro-rotation per stage; the shift and table entry are fixed per stage.
  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_rot
    chs_cordic_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (rot_valid[i]),
      .up_stall   (rot_stall[i]),
      .up_data    (rot_data[i]),
      .down_valid (rot_valid[i+1]),
      .down_stall (rot_stall[i+1]),
      .down_data  (rot_data[i+1])
    );
  end

  // Bring negative angles into the full circle.
  chs_wrap u_wrap (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (rot_valid[NUM_STAGES]),
    .up_stall   (rot_stall[NUM_STAGES]),
    .up_data    (rot_data[NUM_STAGES]),
    .down_valid (ang_valid),
    .down_stall (ang_stall),
    .down_data  (ang_data)
  );

  // Round to 1/64 degree and take the axis override.
  chs_round u_round (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (ang_valid),
    .up_stall   (ang_stall),
    .up_data    (ang_data),
    .down_valid (head_valid),
    .down_stall (head_stall),
    .down_data  (head_data)
  );

  // Classify the sector and hold the result for the consumer.
  chs_sector u_sector (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (head_valid),
    .up_stall   (head_stall),
    .up_data    (head_data),
    .down_valid (result_valid),
    .down_stall (result_stall),
    .down_data  (result)
  );

endmodule

`default_nettype wire
